// ----- rtl/chunked_body_deframer_assert.svh -----
// Assertion macros for the chunked body deframer checker.
// Depends on nothing; included by rtl/cbd_checker.sv.
`ifndef CHUNKED_BODY_DEFRAMER_ASSERT_SVH
`define CHUNKED_BODY_DEFRAMER_ASSERT_SVH

// Check a property while out of reset.
`define CBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cbd_pkg.sv -----
// Package for the chunked body deframer: phase type, status codes, byte codes, hex digit decoder.
// No dependencies; used by rtl/chunked_body_deframer.sv and rtl/cbd_checker.sv.
`timescale 1ns / 1ps

package cbd_pkg;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_DIGITS = 3'd1,
        PH_EXT    = 3'd2,
        PH_DATA   = 3'd3,
        PH_QUIET  = 3'd4
    } phase_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_DATA  = 2'd0;
    localparam status_t ST_END   = 2'd1;
    localparam status_t ST_FRAME = 2'd2;
    localparam status_t ST_OVER  = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one hexadecimal digit in either case
    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        logic [7:0] t;
        r.valid = 1'b0;
        r.value = 4'd0;
        t = 8'd0;
        if (b inside {[8'h30:8'h39]}) begin
            t = b - 8'h30;
            r.valid = 1'b1;
        end else if (b inside {[8'h61:8'h66]}) begin
            t = b - 8'h61 + 8'd10;
            r.valid = 1'b1;
        end else if (b inside {[8'h41:8'h46]}) begin
            t = b - 8'h41 + 8'd10;
            r.valid = 1'b1;
        end
        r.value = t[3:0];
        return r;
    endfunction

endpackage

// ----- rtl/chunked_body_deframer.sv -----
// Chunked body deframer top level: size-line parser, data counter, output register.
// Depends on rtl/cbd_pkg.sv.
`timescale 1ns / 1ps

//  channel | direction | ports                                        | payload
//  s_      | in        | s_valid, s_ready, s_body_byte                | raw body word
//  m_      | out       | m_valid, m_ready, m_payload_byte, m_status,  | payload word or
//          |           | m_chunk_final                                | end/error status
//
//  One input word per cycle while s_ready is high; its result, if any, shows on m_ in the cycle after acceptance.
//  The phase, size and count registers are updated in the cycle of acceptance, so the
//  rate is set by that single state update plus the one-entry output register.
//  s_ready is low only while a result waits and m_ready is low.
//  aresetn (synchronous, active low) returns to the line-break skip phase, no result held.
//  After a body end or an error the block takes every word and gives nothing until reset.

module chunked_body_deframer #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_body_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic [1:0] m_status,
    output logic       m_chunk_final
);

    cbd_pkg::phase_t      phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;

    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_payload_byte_reg, m_payload_byte_next;
    cbd_pkg::status_t     m_status_reg, m_status_next;
    logic                 m_chunk_final_reg, m_chunk_final_next;

    logic                 accept;
    cbd_pkg::hex_digit_t  digit;
    logic                 is_lf;
    logic                 is_break;
    logic                 accum_full;
    logic [SIZE_BITS-1:0] left_dec;
    logic                 left_last;
    logic                 emit;
    logic [7:0]           emit_byte;
    cbd_pkg::status_t     emit_status;
    logic                 emit_final;

    // Accept while the output register is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Decode the incoming word
    assign digit      = cbd_pkg::hex_decode(s_body_byte);
    assign is_lf      = (s_body_byte == cbd_pkg::CHAR_LF);
    assign is_break   = is_lf || (s_body_byte == cbd_pkg::CHAR_CR);
    assign accum_full = (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign left_dec   = bytes_left_reg - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    assign left_last  = (left_dec == '0);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                cbd_pkg::PH_SKIP: begin
                    if (!is_break) begin
                        phase_next = digit.valid ? cbd_pkg::PH_DIGITS : cbd_pkg::PH_EXT;
                    end
                end
                cbd_pkg::PH_DIGITS: begin
                    if (digit.valid) begin
                        phase_next = accum_full ? cbd_pkg::PH_QUIET : cbd_pkg::PH_DIGITS;
                    end else if (is_lf) begin
                        phase_next = (!digit_seen_reg || size_accum_reg == '0)
                                   ? cbd_pkg::PH_QUIET : cbd_pkg::PH_DATA;
                    end else begin
                        phase_next = cbd_pkg::PH_EXT;
                    end
                end
                cbd_pkg::PH_EXT: begin
                    if (is_lf) begin
                        phase_next = (!digit_seen_reg || size_accum_reg == '0)
                                   ? cbd_pkg::PH_QUIET : cbd_pkg::PH_DATA;
                    end
                end
                cbd_pkg::PH_DATA: begin
                    if (left_last) begin
                        phase_next = cbd_pkg::PH_SKIP;
                    end
                end
                default: begin
                    phase_next = cbd_pkg::PH_QUIET;
                end
            endcase
        end
    end

    // Size accumulator, data count and result word
    always_comb begin
        size_accum_next = size_accum_reg;
        digit_seen_next = digit_seen_reg;
        bytes_left_next = bytes_left_reg;
        emit            = 1'b0;
        emit_byte       = 8'd0;
        emit_status     = cbd_pkg::ST_DATA;
        emit_final      = 1'b0;
        if (accept) begin
            case (phase_reg)
                cbd_pkg::PH_SKIP: begin
                    if (!is_break) begin
                        size_accum_next = {{(SIZE_BITS-4){1'b0}}, digit.value};
                        digit_seen_next = digit.valid;
                        if (!digit.valid) begin
                            size_accum_next = '0;
                        end
                    end
                end
                cbd_pkg::PH_DIGITS, cbd_pkg::PH_EXT: begin
                    if (phase_reg == cbd_pkg::PH_DIGITS && digit.valid) begin
                        if (accum_full) begin
                            emit        = 1'b1;
                            emit_status = cbd_pkg::ST_OVER;
                        end else begin
                            size_accum_next = {size_accum_reg[SIZE_BITS-5:0], digit.value};
                            digit_seen_next = 1'b1;
                        end
                    end else if (is_lf) begin
                        if (!digit_seen_reg) begin
                            emit        = 1'b1;
                            emit_status = cbd_pkg::ST_FRAME;
                        end else if (size_accum_reg == '0) begin
                            emit        = 1'b1;
                            emit_status = cbd_pkg::ST_END;
                        end else begin
                            bytes_left_next = size_accum_reg;
                            size_accum_next = '0;
                            digit_seen_next = 1'b0;
                        end
                    end
                end
                cbd_pkg::PH_DATA: begin
                    bytes_left_next = left_dec;
                    emit            = 1'b1;
                    emit_byte       = s_body_byte;
                    emit_final      = left_last;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Load the output register when it is free, hold it while stalled
    always_comb begin
        m_valid_next        = m_valid_reg;
        m_payload_byte_next = m_payload_byte_reg;
        m_status_next       = m_status_reg;
        m_chunk_final_next  = m_chunk_final_reg;
        if (s_ready) begin
            m_valid_next        = emit;
            m_payload_byte_next = emit_byte;
            m_status_next       = emit_status;
            m_chunk_final_next  = emit_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= cbd_pkg::PH_SKIP;
            size_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            bytes_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            digit_seen_reg <= digit_seen_next;
            bytes_left_reg <= bytes_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_byte_reg <= m_payload_byte_next;
        m_status_reg       <= m_status_next;
        m_chunk_final_reg  <= m_chunk_final_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = m_payload_byte_reg;
    assign m_status       = m_status_reg;
    assign m_chunk_final  = m_chunk_final_reg;

endmodule

// ----- rtl/cbd_checker.sv -----
// Port-level checker for the chunked body deframer, bound to the top level.
// Depends on rtl/cbd_pkg.sv and rtl/chunked_body_deframer_assert.svh.
`timescale 1ns / 1ps
`include "chunked_body_deframer_assert.svh"

module cbd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_body_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic [1:0] m_status,
    input logic       m_chunk_final
);

    // Hold a stalled result word
    `CBD_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_payload_byte) && $stable(m_status) && $stable(m_chunk_final), "stalled result word changed")

    // Flag chunk end and carry a byte only on payload words
    `CBD_ASSERT(a_status_clean, aclk, aresetn, m_valid && m_status != cbd_pkg::ST_DATA |-> !m_chunk_final && m_payload_byte == 8'd0, "end or error word carries payload fields")

    // Go quiet after an end or error is taken
    `CBD_ASSERT(a_quiet, aclk, aresetn, m_valid && m_ready && m_status != cbd_pkg::ST_DATA |=> !m_valid, "result after body end or error")

    // Drop any held result on reset
    `CBD_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind chunked_body_deframer cbd_checker u_cbd_checker (.*);
